/* rtl/windowed_mean_min_max_unit_defines.svh */
// Assertion macros for the windowed mean / min / max unit.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef WINDOWED_MEAN_MIN_MAX_UNIT_DEFINES_SVH
`define WINDOWED_MEAN_MIN_MAX_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset.
`define WMMM_ASSERT_NOW(label, clk, rst_n, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (check)) \
        else $error("windowed_mean_min_max_unit: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WMMM_ASSERT_NEXT(label, clk, rst_n, cond, check) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (check)) \
        else $error("windowed_mean_min_max_unit: next-cycle check failed");

`else

`define WMMM_ASSERT_NOW(label, clk, rst_n, cond, check)
`define WMMM_ASSERT_NEXT(label, clk, rst_n, cond, check)

`endif

`endif

/* rtl/wmmm_pkg.sv */
package wmmm_pkg;

    localparam int WINDOW_BITS = 7;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 7'd7;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_WALK  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_LOAD  = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;      // store the request's sample, set up the walk
        logic read;      // read one window entry
        logic div_load;  // start the divider from the finished sum
        logic div_step;  // one quotient bit
        logic out_load;  // move results into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic last_read;
        logic div_last;
        logic out_busy;
    } dp_status_t;

endpackage

/* rtl/windowed_mean_min_max_unit.sv */
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+-------------------------------------------
// sample    | in        | in_valid / in_ready | sample_value
// result    | out       | out_valid/out_ready | window_mean, window_min, window_max,
//           |           |                     | samples_used
// config    | in        | cfg_we (no wait)    | window_days
//
// From accept to result load, a request makes one read of the single-port sample
// ring per window entry, then runs a one-bit-per-cycle restoring divide.
// in_ready is high only while the controller is idle; a new request is taken while
// the previous result still sits in the output register.
// A finished result waits in the controller until the output register is free.
// Reset clears the write position, the held count and the window (to 7); the ring
// itself needs no clearing since only entries already written are read.
`include "windowed_mean_min_max_unit_defines.svh"

module windowed_mean_min_max_unit #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [wmmm_pkg::WINDOW_BITS-1:0] window_days,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         window_mean,
    output logic signed [SAMPLE_BITS-1:0]         window_min,
    output logic signed [SAMPLE_BITS-1:0]         window_max,
    output logic        [wmmm_pkg::WINDOW_BITS-1:0] samples_used
);
    import wmmm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencing: accept, walk the window, divide, hand over.
    wmmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Ring store, window walk with sum/min/max, serial divider, output register.
    wmmm_datapath #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .window_days  (window_days),
        .sample_value (sample_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .window_mean  (window_mean),
        .window_min   (window_min),
        .window_max   (window_max),
        .samples_used (samples_used),
        .cmd          (cmd),
        .status       (status)
    );

    // Hold off further requests once one is taken.
    `WMMM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // A delivered result always covers at least one sample.
    `WMMM_ASSERT_NOW(a_used_nonzero, clk, rst_n, out_valid, samples_used != '0)
    // Minimum never above maximum.
    `WMMM_ASSERT_NOW(a_min_le_max, clk, rst_n, out_valid, window_min <= window_max)
    // Mean lands between minimum and maximum.
    `WMMM_ASSERT_NOW(a_mean_in_range, clk, rst_n, out_valid,
        (window_mean >= window_min) && (window_mean <= window_max))

endmodule

/* rtl/wmmm_ctrl.sv */
module wmmm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  wmmm_pkg::dp_status_t status,
    output wmmm_pkg::dp_cmd_t    cmd
);
    import wmmm_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.read = 1'b1;
                if (status.last_read)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last read word is folded in at this edge
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/wmmm_datapath.sv */
module wmmm_datapath #(
    parameter int DEPTH       = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic        [wmmm_pkg::WINDOW_BITS-1:0] window_days,
    input  logic signed [SAMPLE_BITS-1:0]         sample_value,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [SAMPLE_BITS-1:0]         window_mean,
    output logic signed [SAMPLE_BITS-1:0]         window_min,
    output logic signed [SAMPLE_BITS-1:0]         window_max,
    output logic        [wmmm_pkg::WINDOW_BITS-1:0] samples_used,
    input  wmmm_pkg::dp_cmd_t                     cmd,
    output wmmm_pkg::dp_status_t                  status
);
    import wmmm_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HW   = $clog2(DEPTH + 1);
    localparam int CW   = (HW > WINDOW_BITS) ? HW : WINDOW_BITS;
    localparam int SUMW = SAMPLE_BITS + WINDOW_BITS;
    localparam int DCW  = $clog2(SUMW + 1);
    localparam int RW   = WINDOW_BITS + 1;

    // sample ring
    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    logic        [WINDOW_BITS-1:0] window_days_reg;
    logic        [AW-1:0]          wr_pos_reg;
    logic        [AW-1:0]          wr_pos_next;
    logic        [HW-1:0]          held_reg;
    logic        [HW-1:0]          held_next;
    logic        [WINDOW_BITS-1:0] wanted;
    logic        [CW-1:0]          wanted_ext;
    logic        [CW-1:0]          held_ext;
    logic        [WINDOW_BITS-1:0] used_next;
    logic        [WINDOW_BITS-1:0] used_reg;

    logic        [AW-1:0]          rd_addr_reg;
    logic        [AW-1:0]          rd_addr_next;
    logic        [WINDOW_BITS-1:0] reads_left_reg;
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    logic                          first_reg;
    logic signed [SUMW-1:0]        sum_reg;
    logic signed [SUMW-1:0]        sample_ext;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;

    logic        [SUMW-1:0]        sum_abs;
    logic        [SUMW-1:0]        quo_reg;
    logic        [SUMW-1:0]        quo_next;
    logic        [SUMW-1:0]        quo_signed;
    logic        [RW-1:0]          rem_reg;
    logic        [RW-1:0]          rem_shift;
    logic        [RW-1:0]          div_ext;
    logic        [RW-1:0]          rem_next;
    logic                          neg_reg;
    logic        [DCW-1:0]         div_cnt_reg;

    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] window_mean_reg;
    logic signed [SAMPLE_BITS-1:0] window_min_reg;
    logic signed [SAMPLE_BITS-1:0] window_max_reg;
    logic        [WINDOW_BITS-1:0] samples_used_reg;

    // window bookkeeping at request time
    assign wr_pos_next  = (wr_pos_reg == AW'(DEPTH - 1)) ? '0 : wr_pos_reg + AW'(1);
    assign held_next    = (held_reg == HW'(DEPTH)) ? held_reg : held_reg + HW'(1);
    assign wanted       = (window_days_reg == '0) ? WINDOW_BITS'(1) : window_days_reg;
    assign wanted_ext   = CW'(wanted);
    assign held_ext     = CW'(held_next);
    assign used_next    = (wanted_ext < held_ext) ? wanted : held_ext[WINDOW_BITS-1:0];
    assign rd_addr_next = (rd_addr_reg == '0) ? AW'(DEPTH - 1) : rd_addr_reg - AW'(1);

    assign sample_ext = {{WINDOW_BITS{rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};

    // restoring divide, one quotient bit per step
    assign sum_abs    = sum_reg[SUMW-1] ? (~sum_reg + SUMW'(1)) : sum_reg;
    assign rem_shift  = {rem_reg[WINDOW_BITS-1:0], quo_reg[SUMW-1]};
    assign div_ext    = {1'b0, used_reg};
    assign rem_next   = (rem_shift >= div_ext) ? (rem_shift - div_ext) : rem_shift;
    assign quo_next   = {quo_reg[SUMW-2:0], (rem_shift >= div_ext)};
    assign quo_signed = neg_reg ? (~quo_reg + SUMW'(1)) : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem[wr_pos_reg] <= sample_value;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_days_reg <= WINDOW_RESET;
            wr_pos_reg      <= '0;
            held_reg        <= '0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_days_reg <= window_days;
            end
            if (cmd.load)
            begin
                wr_pos_reg <= wr_pos_next;
                held_reg   <= held_next;
            end
            rd_valid_reg <= cmd.read;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            // newest sample first, walk backward
            rd_addr_reg    <= wr_pos_reg;
            used_reg       <= used_next;
            reads_left_reg <= used_next;
            first_reg      <= 1'b1;
            sum_reg        <= '0;
        end
        if (cmd.read)
        begin
            rd_addr_reg    <= rd_addr_next;
            reads_left_reg <= reads_left_reg - WINDOW_BITS'(1);
        end
        if (rd_valid_reg)
        begin
            first_reg <= 1'b0;
            sum_reg   <= sum_reg + sample_ext;
            if (first_reg || (rd_data_reg < lo_reg))
            begin
                lo_reg <= rd_data_reg;
            end
            if (first_reg || (rd_data_reg > hi_reg))
            begin
                hi_reg <= rd_data_reg;
            end
        end
        if (cmd.div_load)
        begin
            quo_reg     <= sum_abs;
            rem_reg     <= '0;
            neg_reg     <= sum_reg[SUMW-1];
            div_cnt_reg <= DCW'(SUMW);
        end
        if (cmd.div_step)
        begin
            quo_reg     <= quo_next;
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
        if (cmd.out_load)
        begin
            window_mean_reg  <= quo_signed[SAMPLE_BITS-1:0];
            window_min_reg   <= lo_reg;
            window_max_reg   <= hi_reg;
            samples_used_reg <= used_reg;
        end
    end

    assign status.last_read = (reads_left_reg == WINDOW_BITS'(1));
    assign status.div_last  = (div_cnt_reg == DCW'(1));
    assign status.out_busy  = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign window_mean  = window_mean_reg;
    assign window_min   = window_min_reg;
    assign window_max   = window_max_reg;
    assign samples_used = samples_used_reg;

endmodule
